// File: design/hmp_pkg.sv
// ----------------------------------------------------------------------------
// hmp_pkg
// Shared types and constants for the hash message padder: mode codes,
// input command codes, and the controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package hmp_pkg;

  // Hash mode codes held in the configuration register.
  localparam logic [2:0] MODE_MD5    = 3'd0;
  localparam logic [2:0] MODE_SHA1   = 3'd1;
  localparam logic [2:0] MODE_SHA256 = 3'd2;
  localparam logic [2:0] MODE_SHA384 = 3'd3;
  localparam logic [2:0] MODE_SHA512 = 3'd4;
  localparam logic [2:0] MODE_RESET  = MODE_SHA256;

  // Input item command codes.
  localparam logic CMD_DATA   = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  // Block geometry, as byte positions within a block.
  localparam logic [6:0] POS_MASK_64   = 7'h3F;
  localparam logic [6:0] POS_MASK_128  = 7'h7F;
  localparam logic [6:0] LEN_START_64  = 7'd56;
  localparam logic [6:0] LEN_START_128 = 7'd112;
  localparam logic [3:0] LEN_LAST_64   = 4'd7;
  localparam logic [3:0] LEN_LAST_128  = 4'd15;

  localparam logic [7:0] PAD_MARK = 8'h80;

  // Source of the byte pushed into the word packer.
  typedef enum logic [1:0] {
    BSEL_DATA = 2'd0,
    BSEL_MARK = 2'd1,
    BSEL_ZERO = 2'd2,
    BSEL_LEN  = 2'd3
  } hmp_bsel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      push;     // pack one byte this cycle
    hmp_bsel_t bsel;     // which byte to pack
    logic [3:0] len_idx; // length byte index, first sent is 0
    logic      count;    // add one byte to the bit count
    logic      clear;    // end of message: clear position, word and count
    logic      last;     // the word emitted this cycle ends the message
  } hmp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic can_push;  // output register can take a word this cycle
    logic at_target; // block position is where the length field starts
    logic big;       // 128-byte block, 128-bit length
  } hmp_stat_t;

endpackage

// File: design/hmp_datapath.sv
// ----------------------------------------------------------------------------
// hmp_datapath
// Mode register, byte packer, block position, bit counter and output
// register of the hash message padder. Packs one byte per push command.
// ----------------------------------------------------------------------------
module hmp_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [2:0]        cfg_wr_data,
  input  logic [7:0]        in_data_byte,
  input  hmp_pkg::hmp_cmd_t cmd,
  output hmp_pkg::hmp_stat_t stat,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [63:0]       out_word,
  output logic              out_block_end,
  output logic              out_message_end
);
  import hmp_pkg::*;

  logic [2:0]   mode_r;
  logic [6:0]   pos_r, pos_nxt;
  logic [55:0]  acc_r, acc_nxt;
  logic [63:0]  cnt_hi_r, cnt_hi_nxt;
  logic [63:0]  cnt_lo_r, cnt_lo_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [63:0]  out_word_r;
  logic         out_block_end_r;
  logic         out_message_end_r;

  logic         big, md5;
  logic [6:0]   pos_mask, cur_pos, pos_inc;
  logic [3:0]   len_sel;
  logic [127:0] len_full;
  logic [6:0]   len_base;
  logic [7:0]   len_byte;
  logic [7:0]   push_byte;
  logic         emit;
  logic [64:0]  lo_sum;

  // Mode decode.
  assign big      = (mode_r == MODE_SHA384) || (mode_r == MODE_SHA512);
  assign md5      = (mode_r == MODE_MD5);
  assign pos_mask = big ? POS_MASK_128 : POS_MASK_64;
  assign cur_pos  = pos_r & pos_mask;
  assign pos_inc  = (cur_pos + 7'd1) & pos_mask;

  // Length byte: pick a byte of {high, low} counted from the top.
  // MD5 sends the low half least significant byte first.
  assign len_full = {cnt_hi_r, cnt_lo_r};
  always_comb begin
    if (big) begin
      len_sel = cmd.len_idx;
    end else if (md5) begin
      len_sel = 4'd15 - cmd.len_idx;
    end else begin
      len_sel = 4'd8 + cmd.len_idx;
    end
    len_base = {4'd15 - len_sel, 3'b000};
    len_byte = len_full[len_base +: 8];
  end

  // Byte source selection.
  always_comb begin
    unique case (cmd.bsel)
      BSEL_DATA: push_byte = in_data_byte;
      BSEL_MARK: push_byte = PAD_MARK;
      BSEL_ZERO: push_byte = 8'h00;
      BSEL_LEN:  push_byte = len_byte;
      default:   push_byte = 8'h00;
    endcase
  end

  // A word completes when the eighth byte of it is pushed.
  assign emit = cmd.push && (cur_pos[2:0] == 3'b111);

  // Position and partial word.
  always_comb begin
    pos_nxt = pos_r;
    acc_nxt = acc_r;
    if (cmd.clear) begin
      pos_nxt = '0;
      acc_nxt = '0;
    end else if (cmd.push) begin
      pos_nxt = pos_inc;
      acc_nxt = emit ? '0 : {acc_r[47:0], push_byte};
    end
  end

  // Bit count: the high half only counts in 128-bit length modes.
  assign lo_sum = {1'b0, cnt_lo_r} + 65'd8;
  always_comb begin
    cnt_hi_nxt = cnt_hi_r;
    cnt_lo_nxt = cnt_lo_r;
    if (cmd.clear) begin
      cnt_hi_nxt = '0;
      cnt_lo_nxt = '0;
    end else if (cmd.count) begin
      cnt_lo_nxt = lo_sum[63:0];
      if (big && lo_sum[64]) begin
        cnt_hi_nxt = cnt_hi_r + 64'd1;
      end
    end
  end

  // Output register handshake.
  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_RESET;
      pos_r       <= '0;
      acc_r       <= '0;
      cnt_hi_r    <= '0;
      cnt_lo_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      pos_r       <= pos_nxt;
      acc_r       <= acc_nxt;
      cnt_hi_r    <= cnt_hi_nxt;
      cnt_lo_r    <= cnt_lo_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload, loaded when a word completes.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_word_r        <= {acc_r, push_byte};
      out_block_end_r   <= (cur_pos == pos_mask);
      out_message_end_r <= cmd.last;
    end
  end

  assign stat.can_push  = !out_valid_r || out_ready;
  assign stat.at_target = (cur_pos == (big ? LEN_START_128 : LEN_START_64));
  assign stat.big       = big;

  assign out_valid       = out_valid_r;
  assign out_word        = out_word_r;
  assign out_block_end   = out_block_end_r;
  assign out_message_end = out_message_end_r;

endmodule

// File: design/hmp_ctrl.sv
// ----------------------------------------------------------------------------
// hmp_ctrl
// Controller of the hash message padder. Takes input items and sequences
// the padding of a finished message one byte per cycle when not stalled.
// ----------------------------------------------------------------------------
module hmp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_command,
  input  hmp_pkg::hmp_stat_t stat,
  output hmp_pkg::hmp_cmd_t  cmd
);
  import hmp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MARK = 4'b0010,
    S_ZERO = 4'b0100,
    S_LEN  = 4'b1000
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic [3:0] last_idx;

  assign last_idx = stat.big ? LEN_LAST_128 : LEN_LAST_64;

  // Next state and datapath commands.
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    in_ready    = 1'b0;
    cmd.push    = 1'b0;
    cmd.bsel    = BSEL_DATA;
    cmd.len_idx = idx_r;
    cmd.count   = 1'b0;
    cmd.clear   = 1'b0;
    cmd.last    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = stat.can_push;
        if (in_valid && stat.can_push) begin
          if (in_command == CMD_FINISH) begin
            state_nxt = S_MARK;
            idx_nxt   = '0;
          end else begin
            cmd.push  = 1'b1;
            cmd.count = 1'b1;
          end
        end
      end
      S_MARK: begin
        cmd.bsel = BSEL_MARK;
        if (stat.can_push) begin
          cmd.push  = 1'b1;
          state_nxt = S_ZERO;
        end
      end
      S_ZERO: begin
        cmd.bsel = BSEL_ZERO;
        if (stat.at_target) begin
          state_nxt = S_LEN;
        end else if (stat.can_push) begin
          cmd.push = 1'b1;
        end
      end
      S_LEN: begin
        cmd.bsel = BSEL_LEN;
        if (stat.can_push) begin
          cmd.push = 1'b1;
          if (idx_r == last_idx) begin
            cmd.last  = 1'b1;
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + 4'd1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

// File: design/hash_message_padder.sv
// ----------------------------------------------------------------------------
// hash_message_padder
// Merkle-Damgard message padding for MD5, SHA-1, SHA-256, SHA-384, SHA-512.
//
// Usage: message bytes enter on the in_ channel (in_command 0 with
// in_data_byte); in_command 1 finishes the message. Padded 64-bit words leave
// on the out_ channel, first byte in bits 63..56, with out_block_end on the
// last word of each hash block and out_message_end on the last word of the
// message. cfg_wr_data selects the mode and is written when cfg_wr_en is high;
// the user must write it only while the block is idle; the block does not enforce this.
// Throughput: one data byte per cycle while the output is not stalled; a word
// is registered and appears in the cycle after its eighth byte is accepted.
// A finish item packs the 0x80 marker, the zero fill and the 8 or 16 length
// bytes one byte per cycle, when not stalled, through the single byte packer,
// with a pause where the fill reaches the length field, and all of the padding
// is packed before the next item is taken.
// Reset clears the message state and sets the mode to SHA-256. When the
// receiver stalls, the output register holds its word and packing stops until
// the word is taken; input is not accepted meanwhile.
// ----------------------------------------------------------------------------
module hash_message_padder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_word,
  output logic        out_block_end,
  output logic        out_message_end
);
  import hmp_pkg::*;

  hmp_cmd_t  cmd;
  hmp_stat_t stat;

  // Sequencer.
  hmp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Byte packer, counter and output register.
  hmp_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_data_byte    (in_data_byte),
    .cmd             (cmd),
    .stat            (stat),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_word        (out_word),
    .out_block_end   (out_block_end),
    .out_message_end (out_message_end)
  );

endmodule
